// ----- design/cpps_pkg.sv -----
package cpps_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int TOT_W        = CNT_W + 1;
    localparam int COORD_W      = 32;
    localparam int ENTRY_W      = 4 * COORD_W + 2;

    localparam logic signed [17:0] ONE_Q16     = 18'sd65536;
    localparam logic signed [17:0] NEG_ONE_Q16 = -18'sd65536;

    localparam logic [1:0] SIDE_COPLANAR = 2'd0;
    localparam logic [1:0] SIDE_FRONT    = 2'd1;
    localparam logic [1:0] SIDE_BACK     = 2'd2;

    localparam logic [1:0] MODE_FRONT = 2'd0;
    localparam logic [1:0] MODE_BACK  = 2'd1;
    localparam logic [1:0] MODE_BOTH  = 2'd2;

    typedef enum logic [2:0] {
        CFG_NORMAL_X      = 3'd0,
        CFG_NORMAL_Y      = 3'd1,
        CFG_NORMAL_Z      = 3'd2,
        CFG_PLANE_OFFSET  = 3'd3,
        CFG_TOLERANCE     = 3'd4,
        CFG_COPLANAR_MODE = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DX,
        MUL_DY,
        MUL_DZ,
        MUL_LX,
        MUL_LY,
        MUL_LZ
    } mul_op_t;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_X,
        FIN_Y,
        FIN_Z
    } fin_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MX,
        ST_MY,
        ST_MZ,
        ST_SUM,
        ST_DIST,
        ST_WR,
        ST_DECIDE,
        ST_EMPTY,
        ST_RD0,
        ST_LAT0,
        ST_RDN,
        ST_LATN,
        ST_EVTX,
        ST_DIVI,
        ST_DIV,
        ST_LX,
        ST_LY,
        ST_LZ,
        ST_LW,
        ST_ECRS,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    load_vtx;
        mul_op_t mul_op;
        logic    acc_load;
        logic    acc_add;
        logic    dist_load;
        logic    store_vtx;
        logic    rd_first;
        logic    latch_first;
        logic    rd_next;
        logic    latch_next;
        logic    emit_vtx;
        logic    emit_cross;
        logic    emit_empty;
        logic    div_start;
        logic    div_step;
        fin_t    fin;
        logic    advance;
        logic    clear;
    } cmd_t;

    typedef struct packed {
        logic fin;
        logic n_ge3;
        logic split;
        logic emit_any;
        logic crossing;
        logic last_edge;
        logic out_free;
        logic div_last;
    } status_t;

endpackage

// ----- design/cpps_ram.sv -----
module cpps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/cpps_ctrl.sv -----
module cpps_ctrl
    import cpps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        cmd.fin    = FIN_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_vtx = 1'b1;
                    state_next   = ST_MX;
                end
            end
            ST_MX:
            begin
                cmd.mul_op = MUL_DX;
                state_next = ST_MY;
            end
            ST_MY:
            begin
                cmd.mul_op   = MUL_DY;
                cmd.acc_load = 1'b1;
                state_next   = ST_MZ;
            end
            ST_MZ:
            begin
                cmd.mul_op  = MUL_DZ;
                cmd.acc_add = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_DIST;
            end
            ST_DIST:
            begin
                cmd.dist_load = 1'b1;
                state_next    = ST_WR;
            end
            ST_WR:
            begin
                cmd.store_vtx = 1'b1;
                state_next    = status.fin ? ST_DECIDE : ST_IDLE;
            end
            ST_DECIDE:
            begin
                if (status.n_ge3 && (status.split || status.emit_any))
                begin
                    state_next = ST_RD0;
                end
                else
                begin
                    state_next = ST_EMPTY;
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_RD0:
            begin
                cmd.rd_first = 1'b1;
                state_next   = ST_LAT0;
            end
            ST_LAT0:
            begin
                cmd.latch_first = 1'b1;
                state_next      = ST_RDN;
            end
            ST_RDN:
            begin
                cmd.rd_next = 1'b1;
                state_next  = ST_LATN;
            end
            ST_LATN:
            begin
                cmd.latch_next = 1'b1;
                state_next     = ST_EVTX;
            end
            ST_EVTX:
            begin
                if (status.out_free)
                begin
                    cmd.emit_vtx = 1'b1;
                    if (status.crossing)
                    begin
                        state_next = ST_DIVI;
                    end
                    else if (status.last_edge)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_DIVI:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_LX;
                end
            end
            ST_LX:
            begin
                cmd.mul_op = MUL_LX;
                state_next = ST_LY;
            end
            ST_LY:
            begin
                cmd.mul_op = MUL_LY;
                cmd.fin    = FIN_X;
                state_next = ST_LZ;
            end
            ST_LZ:
            begin
                cmd.mul_op = MUL_LZ;
                cmd.fin    = FIN_Y;
                state_next = ST_LW;
            end
            ST_LW:
            begin
                cmd.fin    = FIN_Z;
                state_next = ST_ECRS;
            end
            ST_ECRS:
            begin
                if (status.out_free)
                begin
                    cmd.emit_cross = 1'b1;
                    state_next     = status.last_edge ? ST_DONE : ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                cmd.advance = 1'b1;
                state_next  = ST_RDN;
            end
            ST_DONE:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/cpps_datapath.sv -----
module cpps_datapath
    import cpps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [95:0]   s_tdata,
    input  logic          s_tlast,
    input  logic          cfg_valid,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          m_tready,
    output logic          m_tvalid,
    output logic [111:0]  m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast,
    input  cmd_t          cmd,
    output status_t       status
);

    logic signed [17:0] nx_reg, ny_reg, nz_reg;
    logic signed [31:0] off_reg;
    logic [30:0]        tol_reg;
    logic [1:0]         mode_reg;

    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic               fin_reg;

    logic signed [67:0] prod_reg;
    logic signed [51:0] acc_reg;
    logic signed [31:0] dist_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [2:0]         seen_reg;
    logic               ovf_reg;
    logic [TOT_W-1:0]   fcnt_reg, bcnt_reg;

    logic [ENTRY_W-1:0] cur_reg, nxt_reg, first_reg;
    logic [ADDR_W-1:0]  idx_reg;

    logic [33:0]        rem_reg;
    logic [32:0]        den_reg;
    logic [29:0]        q_reg;
    logic [4:0]         dcnt_reg;
    logic               dsat_reg, dzero_reg;

    logic signed [31:0] cx_reg, cy_reg, cz_reg;

    logic               ov_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic               of_reg, ob_reg, oend_reg, oovf_reg;
    logic [5:0]         oft_reg, obt_reg;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh07fffffff)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -34'sh080000000)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [32:0] diff33(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] r;
        r = {b[31], b} - {a[31], a};
        return r;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : v;
        return r;
    endfunction

    // entry fields
    logic signed [31:0] cur_x, cur_y, cur_z, cur_d, nxt_x, nxt_y, nxt_z, nxt_d;
    logic [1:0]         cur_side, nxt_side;

    assign cur_x    = cur_reg[31:0];
    assign cur_y    = cur_reg[63:32];
    assign cur_z    = cur_reg[95:64];
    assign cur_d    = cur_reg[127:96];
    assign cur_side = cur_reg[129:128];
    assign nxt_x    = nxt_reg[31:0];
    assign nxt_y    = nxt_reg[63:32];
    assign nxt_z    = nxt_reg[95:64];
    assign nxt_d    = nxt_reg[127:96];
    assign nxt_side = nxt_reg[129:128];

    // plane decision
    logic to_f, to_b, split, crossing, last_edge, out_free;

    always_comb
    begin
        split = (seen_reg[1:0] == 2'b11);
        if (seen_reg[1:0] == 2'b00)
        begin
            to_f = (mode_reg == MODE_FRONT) || (mode_reg == MODE_BOTH);
            to_b = (mode_reg == MODE_BACK) || (mode_reg == MODE_BOTH);
        end
        else
        begin
            to_f = seen_reg[0];
            to_b = seen_reg[1];
        end
    end

    assign crossing  = split && (cur_side != SIDE_COPLANAR) && (nxt_side != SIDE_COPLANAR)
                       && (cur_side != nxt_side);
    assign last_edge = ({1'b0, idx_reg} + CNT_W'(1)) == count_reg;
    assign out_free  = !ov_reg || m_tready;

    assign status.fin       = fin_reg;
    assign status.n_ge3     = count_reg >= CNT_W'(3);
    assign status.split     = split;
    assign status.emit_any  = to_f || to_b;
    assign status.crossing  = crossing;
    assign status.last_edge = last_edge;
    assign status.out_free  = out_free;
    assign status.div_last  = (dcnt_reg == 5'd0);

    // shared multiplier
    logic [30:0]        t_val;
    logic signed [33:0] ma, mb;

    assign t_val = dsat_reg ? 31'h40000000 : {1'b0, q_reg};

    always_comb
    begin
        case (cmd.mul_op)
            MUL_DX:
            begin
                ma = 34'(nx_reg);
                mb = 34'(vx_reg);
            end
            MUL_DY:
            begin
                ma = 34'(ny_reg);
                mb = 34'(vy_reg);
            end
            MUL_DZ:
            begin
                ma = 34'(nz_reg);
                mb = 34'(vz_reg);
            end
            MUL_LX:
            begin
                ma = {3'b000, t_val};
                mb = {1'b0, mag33(diff33(cur_x, nxt_x))};
            end
            MUL_LY:
            begin
                ma = {3'b000, t_val};
                mb = {1'b0, mag33(diff33(cur_y, nxt_y))};
            end
            MUL_LZ:
            begin
                ma = {3'b000, t_val};
                mb = {1'b0, mag33(diff33(cur_z, nxt_z))};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // distance
    logic signed [52:0] rnd;
    logic signed [36:0] shf;
    logic signed [37:0] dd;
    logic signed [32:0] dext, tol_ext;
    logic [1:0]         new_side;

    assign rnd     = {acc_reg[51], acc_reg} + 53'sd32768;
    assign shf     = rnd[52:16];
    assign dd      = {shf[36], shf} - 38'(off_reg);
    assign dext    = {dist_reg[31], dist_reg};
    assign tol_ext = {2'b00, tol_reg};

    always_comb
    begin
        if (dext < -tol_ext)
        begin
            new_side = SIDE_BACK;
        end
        else if (dext > tol_ext)
        begin
            new_side = SIDE_FRONT;
        end
        else
        begin
            new_side = SIDE_COPLANAR;
        end
    end

    // crossing coordinate finish
    logic signed [31:0] fa, fb, neg_off, lerp_v, fin_v;
    logic signed [17:0] fn;
    logic signed [32:0] fdelta;
    logic [62:0]        rsum;
    logic [32:0]        foff;

    assign neg_off = (off_reg == 32'sh80000000) ? 32'sh7fffffff : -off_reg;

    always_comb
    begin
        case (cmd.fin)
            FIN_Y:
            begin
                fa = cur_y;
                fb = nxt_y;
                fn = ny_reg;
            end
            FIN_Z:
            begin
                fa = cur_z;
                fb = nxt_z;
                fn = nz_reg;
            end
            default:
            begin
                fa = cur_x;
                fb = nxt_x;
                fn = nx_reg;
            end
        endcase
        fdelta = diff33(fa, fb);
        rsum   = prod_reg[62:0] + 63'h20000000;
        foff   = rsum[62:30];
        if (fdelta[32])
        begin
            lerp_v = sat34(34'(fa) - {1'b0, foff});
        end
        else
        begin
            lerp_v = sat34(34'(fa) + {1'b0, foff});
        end
        if (dzero_reg)
        begin
            fin_v = fa;
        end
        else if (fn == ONE_Q16)
        begin
            fin_v = off_reg;
        end
        else if (fn == NEG_ONE_Q16)
        begin
            fin_v = neg_off;
        end
        else
        begin
            fin_v = lerp_v;
        end
    end

    // divider step
    logic [33:0]        r2;
    logic               r_ge;
    logic [31:0]        a_mag;
    logic [32:0]        den_mag;

    assign r2      = {rem_reg[32:0], 1'b0};
    assign r_ge    = r2 >= {1'b0, den_reg};
    assign a_mag   = cur_d[31] ? 32'(-cur_d) : cur_d;
    assign den_mag = mag33(diff33(nxt_d, cur_d));

    // emission values
    logic               e_f, e_b, e_end, e_valid;
    logic signed [31:0] e_x, e_y, e_z;
    logic [TOT_W-1:0]   fsum, bsum;

    always_comb
    begin
        e_valid = cmd.emit_vtx || cmd.emit_cross || cmd.emit_empty;
        e_x     = '0;
        e_y     = '0;
        e_z     = '0;
        e_f     = 1'b0;
        e_b     = 1'b0;
        e_end   = 1'b0;
        if (cmd.emit_vtx)
        begin
            e_x   = cur_x;
            e_y   = cur_y;
            e_z   = cur_z;
            e_end = last_edge && !crossing;
            if (split)
            begin
                e_f = (cur_side != SIDE_BACK);
                e_b = (cur_side != SIDE_FRONT);
            end
            else
            begin
                e_f = to_f;
                e_b = to_b;
            end
        end
        else if (cmd.emit_cross)
        begin
            e_x   = cx_reg;
            e_y   = cy_reg;
            e_z   = cz_reg;
            e_f   = 1'b1;
            e_b   = 1'b1;
            e_end = last_edge;
        end
        else if (cmd.emit_empty)
        begin
            e_end = 1'b1;
        end
        fsum = fcnt_reg + TOT_W'(e_f);
        bsum = bcnt_reg + TOT_W'(e_b);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg    <= ONE_Q16;
            ny_reg    <= '0;
            nz_reg    <= '0;
            off_reg   <= '0;
            tol_reg   <= '0;
            mode_reg  <= MODE_BOTH;
            count_reg <= '0;
            seen_reg  <= '0;
            ovf_reg   <= 1'b0;
            fcnt_reg  <= '0;
            bcnt_reg  <= '0;
            ov_reg    <= 1'b0;
            dcnt_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_NORMAL_X:      nx_reg   <= cfg_data[17:0];
                    CFG_NORMAL_Y:      ny_reg   <= cfg_data[17:0];
                    CFG_NORMAL_Z:      nz_reg   <= cfg_data[17:0];
                    CFG_PLANE_OFFSET:  off_reg  <= cfg_data;
                    CFG_TOLERANCE:     tol_reg  <= cfg_data[30:0];
                    CFG_COPLANAR_MODE: mode_reg <= cfg_data[1:0];
                    default:           ;
                endcase
            end
            if (cmd.store_vtx)
            begin
                if (count_reg < CNT_W'(MAX_VERTICES))
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    case (new_side)
                        SIDE_BACK:  seen_reg[1] <= 1'b1;
                        SIDE_FRONT: seen_reg[0] <= 1'b1;
                        default:    seen_reg[2] <= 1'b1;
                    endcase
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (e_valid)
            begin
                fcnt_reg <= fsum;
                bcnt_reg <= bsum;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
                seen_reg  <= '0;
                ovf_reg   <= 1'b0;
                fcnt_reg  <= '0;
                bcnt_reg  <= '0;
            end
            if (e_valid)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
            if (cmd.div_start)
            begin
                dcnt_reg <= 5'd29;
            end
            else if (cmd.div_step && dcnt_reg != 5'd0)
            begin
                dcnt_reg <= dcnt_reg - 5'd1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_vtx)
        begin
            vx_reg  <= s_tdata[31:0];
            vy_reg  <= s_tdata[63:32];
            vz_reg  <= s_tdata[95:64];
            fin_reg <= s_tlast;
        end
        prod_reg <= ma * mb;
        if (cmd.acc_load)
        begin
            acc_reg <= prod_reg[51:0];
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + prod_reg[51:0];
        end
        if (cmd.dist_load)
        begin
            if (dd > 38'sh007fffffff)
            begin
                dist_reg <= 32'sh7fffffff;
            end
            else if (dd < -38'sh0080000000)
            begin
                dist_reg <= 32'sh80000000;
            end
            else
            begin
                dist_reg <= dd[31:0];
            end
        end
        if (cmd.latch_first)
        begin
            cur_reg   <= ram_rdata;
            first_reg <= ram_rdata;
            idx_reg   <= '0;
        end
        if (cmd.latch_next)
        begin
            nxt_reg <= last_edge ? first_reg : ram_rdata;
        end
        if (cmd.advance)
        begin
            cur_reg <= nxt_reg;
            idx_reg <= idx_reg + ADDR_W'(1);
        end
        if (cmd.div_start)
        begin
            rem_reg   <= {2'b00, a_mag};
            den_reg   <= den_mag;
            q_reg     <= '0;
            dsat_reg  <= {1'b0, a_mag} >= den_mag;
            dzero_reg <= (den_mag == 33'd0);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= r_ge ? (r2 - {1'b0, den_reg}) : r2;
            q_reg   <= {q_reg[28:0], r_ge};
        end
        case (cmd.fin)
            FIN_X:   cx_reg <= fin_v;
            FIN_Y:   cy_reg <= fin_v;
            FIN_Z:   cz_reg <= fin_v;
            default: ;
        endcase
        if (e_valid)
        begin
            ox_reg   <= e_x;
            oy_reg   <= e_y;
            oz_reg   <= e_z;
            of_reg   <= e_f;
            ob_reg   <= e_b;
            oend_reg <= e_end;
            oovf_reg <= ovf_reg;
            oft_reg  <= e_end ? fsum[5:0] : 6'd0;
            obt_reg  <= e_end ? bsum[5:0] : 6'd0;
        end
    end

    assign ram_we    = cmd.store_vtx && (count_reg < CNT_W'(MAX_VERTICES));
    assign ram_wdata = {new_side, dist_reg, vz_reg, vy_reg, vx_reg};
    assign ram_re    = cmd.rd_first || cmd.rd_next;
    assign ram_raddr = cmd.rd_next ? (idx_reg + ADDR_W'(1)) : '0;

    cpps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = ov_reg;
    assign m_tdata  = {3'b000, oovf_reg, obt_reg, oft_reg, oz_reg, oy_reg, ox_reg};
    assign m_tuser  = {ob_reg, of_reg};
    assign m_tlast  = oend_reg;

endmodule

// ----- design/convex_polygon_plane_split_core.sv -----
// channel  dir  handshake                   payload
// s_*      in   s_tvalid / s_tready         vertex x, y, z; tlast marks final vertex
// m_*      out  m_tvalid / m_tready         result vertex, totals, overflow; tuser sides
// cfg_*    in   cfg_valid / cfg_ready       register index and write data
//
// a vertex makes three passes through the one shared multiplier for the dot product,
// then sum, rounding and classify/store; one vertex is in work at a time
// emission walks the vertex memory one entry per fetch, and each crossing adds a pass
// through the bit-serial divider followed by interpolation
// a full output register stalls emission until m_tready takes the beat
// reset returns registers to their defaults and clears the polygon; no clearing pass
module convex_polygon_plane_split_core
    import cpps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // out_x, out_y, out_z, front_total, back_total, overflowed
    output logic [1:0]   m_tuser,   // to_front, to_back
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    cpps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cpps_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
